// File: sv/ubx_rx_pkg.sv
// shared types and constants for the ubx frame receiver
`default_nettype none

package ubx_rx_pkg;

    // frame buffer size and the body limit, the smaller of the buffer room and a fixed cap
    localparam int BUF_BYTES    = 256;
    localparam int CHECK_BYTES  = 2;
    localparam int HEADER_BYTES = 4;
    localparam int BODY_CAP     = 256 - 10;
    localparam int BODY_ROOM    = BUF_BYTES - CHECK_BYTES;
    localparam int BODY_LIMIT   = (BODY_ROOM < BODY_CAP) ? BODY_ROOM : BODY_CAP;

    // sync pair
    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    // receiver phase
    typedef enum logic [3:0] {
        PH_HUNT    = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CHK_A   = 4'd7,
        PH_CHK_B   = 4'd8,
        PH_ABORT   = 4'd9
    } phase_t;

    // result kind
    typedef enum logic [1:0] {
        KIND_BODY  = 2'd0,
        KIND_GOOD  = 2'd1,
        KIND_BAD   = 2'd2,
        KIND_ABORT = 2'd3
    } kind_t;

endpackage

`default_nettype wire

// File: sv/ubx_rx_if.sv
// request channels for received bytes and for frame results
`default_nettype none

interface ubx_rx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ubx_rx_result_if
    import ubx_rx_pkg::*;
;
    logic       valid;
    logic       ready;
    kind_t      kind;
    logic [7:0] body_byte;
    logic [7:0] byte_index;
    logic       frame_last;

    modport source (output valid, output kind, output body_byte, output byte_index,
                    output frame_last, input ready);
    modport sink   (input valid, input kind, input body_byte, input byte_index,
                    input frame_last, output ready);
endinterface

`default_nettype wire

// File: sv/ubx_frame_receiver_core.sv
// ubx frame receiver: sync hunt, body collection and fletcher-8 checksum
// path: a byte goes from the input register through the state and sum update into
// the result register, from which its result, if any, is offered; a result stall holds it
// throughput: one byte per cycle while the result side does not stall
// while a result waits, one more byte can still be held in the input register
// reset: asynchronous active-low rst_n empties both registers, hunts for sync
`default_nettype none

module ubx_frame_receiver_core
    import ubx_rx_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    ubx_rx_byte_if.sink         rx,
    ubx_rx_result_if.source     result
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // receiver state
    phase_t      phase_reg, phase_next;
    logic [7:0]  body_count_reg, body_count_next;
    logic [15:0] decl_len_reg, decl_len_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  rx_sum_a_reg, rx_sum_a_next;

    // result register
    logic       out_valid_reg;
    kind_t      out_kind_reg;
    logic [7:0] out_byte_reg;
    logic [7:0] out_index_reg;
    logic       out_last_reg;

    // combinational result
    logic       res_valid;
    kind_t      res_kind;
    logic [7:0] res_byte;
    logic [7:0] res_index;

    logic        out_free;
    logic        advance;
    logic [7:0]  count_inc;
    logic [7:0]  sum_a_inc;
    logic [15:0] len_hi_value;
    logic [16:0] payload_end;

    // handshake between the two registers
    assign out_free  = !out_valid_reg || result.ready;
    assign advance   = in_valid_reg && out_free;
    assign rx.ready  = !in_valid_reg || advance;

    assign count_inc    = body_count_reg + 8'd1;
    assign sum_a_inc    = sum_a_reg + in_byte_reg;
    assign len_hi_value = {in_byte_reg, decl_len_reg[7:0]};
    assign payload_end  = {1'b0, decl_len_reg} + 17'(HEADER_BYTES);

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (in_byte_reg == SYNC_FIRST)
                begin
                    phase_next = PH_SYNC2;
                end
            end
            PH_SYNC2:
            begin
                phase_next = (in_byte_reg == SYNC_SECOND) ? PH_CLASS : PH_HUNT;
            end
            PH_CLASS:   phase_next = PH_ID;
            PH_ID:      phase_next = PH_LEN_LO;
            PH_LEN_LO:  phase_next = PH_LEN_HI;
            PH_LEN_HI:
            begin
                phase_next = (len_hi_value == 16'd0) ? PH_CHK_A : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                priority if ({9'd0, count_inc} >= payload_end)
                begin
                    phase_next = PH_CHK_A;
                end
                else if (count_inc >= 8'(BODY_LIMIT))
                begin
                    phase_next = PH_ABORT;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_CHK_A:   phase_next = PH_CHK_B;
            PH_CHK_B:   phase_next = PH_HUNT;
            PH_ABORT:   phase_next = PH_HUNT;
            default:    phase_next = PH_HUNT;
        endcase
    end

    // result and datapath updates
    always_comb
    begin
        res_valid       = 1'b0;
        res_kind        = KIND_BODY;
        res_byte        = 8'd0;
        res_index       = body_count_reg;
        body_count_next = body_count_reg;
        decl_len_next   = decl_len_reg;
        sum_a_next      = sum_a_reg;
        sum_b_next      = sum_b_reg;
        rx_sum_a_next   = rx_sum_a_reg;
        unique case (phase_reg)
            PH_HUNT:
            begin
            end
            PH_SYNC2:
            begin
                // frame start clears counter and sums, a miss clears the counter
                body_count_next = 8'd0;
                if (in_byte_reg == SYNC_SECOND)
                begin
                    sum_a_next = 8'd0;
                    sum_b_next = 8'd0;
                end
            end
            PH_CLASS, PH_ID, PH_LEN_LO, PH_LEN_HI, PH_PAYLOAD:
            begin
                res_valid       = 1'b1;
                res_byte        = in_byte_reg;
                sum_a_next      = sum_a_inc;
                sum_b_next      = sum_b_reg + sum_a_inc;
                body_count_next = count_inc;
                if (phase_reg == PH_LEN_LO)
                begin
                    decl_len_next = {decl_len_reg[15:8], in_byte_reg};
                end
                if (phase_reg == PH_LEN_HI)
                begin
                    decl_len_next = len_hi_value;
                end
            end
            PH_CHK_A:
            begin
                rx_sum_a_next = in_byte_reg;
            end
            PH_CHK_B:
            begin
                res_valid       = 1'b1;
                res_kind        = ((rx_sum_a_reg == sum_a_reg) && (in_byte_reg == sum_b_reg))
                                  ? KIND_GOOD : KIND_BAD;
                body_count_next = 8'd0;
            end
            PH_ABORT:
            begin
                res_valid       = 1'b1;
                res_kind        = KIND_ABORT;
                body_count_next = 8'd0;
            end
            default:
            begin
                body_count_next = 8'd0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            body_count_reg <= 8'd0;
            decl_len_reg   <= 16'd0;
            sum_a_reg      <= 8'd0;
            sum_b_reg      <= 8'd0;
            rx_sum_a_reg   <= 8'd0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            body_count_reg <= body_count_next;
            decl_len_reg   <= decl_len_next;
            sum_a_reg      <= sum_a_next;
            sum_b_reg      <= sum_b_next;
            rx_sum_a_reg   <= rx_sum_a_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_kind_reg  <= res_kind;
            out_byte_reg  <= res_byte;
            out_index_reg <= res_index;
            out_last_reg  <= (res_kind != KIND_BODY);
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.kind       = out_kind_reg;
    assign result.body_byte  = out_byte_reg;
    assign result.byte_index = out_index_reg;
    assign result.frame_last = out_last_reg;

    // counter is always clear while hunting
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HUNT |-> body_count_reg == 8'd0)
        else $error("body counter not clear while hunting");

    // second checksum byte always produces a frame end request
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && phase_reg == PH_CHK_B |=> out_valid_reg && out_last_reg)
        else $error("checksum byte gave no frame end");

    // body positions stay below the body limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == KIND_BODY |-> out_index_reg < 8'(BODY_LIMIT))
        else $error("body index beyond limit");

    // a pending byte is not dropped while the result side stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("pending byte lost");

endmodule

`default_nettype wire

// File: tb/sv/ubx_frame_receiver_core_tb.sv
// testbench for the ubx frame receiver: directed and random byte streams, scoreboard checks
module ubx_frame_receiver_core_tb;
    import ubx_rx_pkg::*;

    // frame damage, payload fill and cut codes for the frame builder, and test length limits
    localparam int SPOIL_NONE  = 0;
    localparam int SPOIL_SUM_A = 1;
    localparam int SPOIL_SUM_B = 2;
    localparam int FILL_RANDOM = -1;
    localparam int NO_CUT      = -1;
    localparam int SEND_CAP    = 250;
    localparam int RANDOM_BYTES = 200;
    localparam int SETTLE_CYCLES = 5000;
    localparam int HUGE_CUT    = 30;

    typedef struct {
        kind_t      kind;
        logic [7:0] body_byte;
        logic [7:0] byte_index;
        logic       frame_last;
    } frame_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ubx_rx_byte_if   rx_ch();
    ubx_rx_result_if res_ch();

    ubx_frame_receiver_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch)
    );

    // shadow copy of the receiver state
    phase_t     rx_phase    = PH_HUNT;
    logic [7:0] rx_count    = 8'd0;
    logic [15:0] rx_declared = 16'd0;
    logic [7:0] rx_sum_a    = 8'd0;
    logic [7:0] rx_sum_b    = 8'd0;
    logic [7:0] rx_got_a    = 8'd0;

    frame_item_t items_due[$];
    frame_item_t want;

    bit calm = 1'b0;
    int fail_count  = 0;
    int bytes_sent  = 0;
    int seen_body   = 0;
    int seen_good   = 0;
    int seen_bad    = 0;
    int seen_abort  = 0;
    int stall_left  = 0;

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #6000000;
        $display("timeout: byte stream or result stream stuck at %0t", $time);
        $display("*** FAILED ***");
        $finish;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 8);
        return $urandom_range(9, 20);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_val, $time);
        fail_count++;
    endtask

    task automatic push_due(input kind_t kind, input logic [7:0] value,
                            input logic [7:0] index, input logic last);
        frame_item_t item;
        item.kind       = kind;
        item.body_byte  = value;
        item.byte_index = index;
        item.frame_last = last;
        items_due.push_back(item);
    endtask

    // one body byte: emit, fold into fletcher sums, advance count
    task automatic take_body(input logic [7:0] b);
        push_due(KIND_BODY, b, rx_count, 1'b0);
        rx_sum_a = rx_sum_a + b;
        rx_sum_b = rx_sum_b + rx_sum_a;
        rx_count = rx_count + 8'd1;
    endtask

    task automatic back_to_hunt();
        rx_phase = PH_HUNT;
        rx_count = 8'd0;
    endtask

    // advance the shadow receiver by one accepted byte
    task automatic track_receiver(input logic [7:0] b);
        case (rx_phase)
            PH_HUNT:
                if (b == SYNC_FIRST)
                    rx_phase = PH_SYNC2;
            PH_SYNC2:
                if (b == SYNC_SECOND)
                begin
                    rx_phase = PH_CLASS;
                    rx_count = 8'd0;
                    rx_sum_a = 8'd0;
                    rx_sum_b = 8'd0;
                end
                else
                    back_to_hunt();
            PH_CLASS:
            begin
                rx_phase = PH_ID;
                take_body(b);
            end
            PH_ID:
            begin
                rx_phase = PH_LEN_LO;
                take_body(b);
            end
            PH_LEN_LO:
            begin
                rx_declared[7:0] = b;
                rx_phase = PH_LEN_HI;
                take_body(b);
            end
            PH_LEN_HI:
            begin
                rx_declared[15:8] = b;
                if (rx_declared == 16'd0)
                    rx_phase = PH_CHK_A;
                else
                    rx_phase = PH_PAYLOAD;
                take_body(b);
            end
            PH_PAYLOAD:
            begin
                take_body(b);
                if (int'(rx_count) >= int'(rx_declared) + HEADER_BYTES)
                    rx_phase = PH_CHK_A;
                else if (int'(rx_count) >= BODY_LIMIT)
                    rx_phase = PH_ABORT;
            end
            PH_CHK_A:
            begin
                rx_got_a = b;
                rx_phase = PH_CHK_B;
            end
            PH_CHK_B:
            begin
                if (rx_got_a == rx_sum_a && b == rx_sum_b)
                    push_due(KIND_GOOD, 8'd0, rx_count, 1'b1);
                else
                    push_due(KIND_BAD, 8'd0, rx_count, 1'b1);
                back_to_hunt();
            end
            PH_ABORT:
            begin
                push_due(KIND_ABORT, 8'd0, rx_count, 1'b1);
                back_to_hunt();
            end
            default:
                back_to_hunt();
        endcase
    endtask

    // send one byte request; returns just after the accepting edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        bytes_sent++;
        track_receiver(b);
    endtask

    // lower valid and wait for every expected result, bounded
    task automatic settle_results();
        int waited;
        waited = 0;
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        while (items_due.size() != 0 && waited < SETTLE_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    // build a whole frame with its checksum, optionally damaged or cut short
    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len, input int fill,
                              input int spoil, input int cut);
        logic [7:0] frame_bytes[$];
        logic [7:0] sum_a;
        logic [7:0] sum_b;
        logic [7:0] b;
        int n;
        int stop;
        sum_a = 8'd0;
        sum_b = 8'd0;
        n = (int'(len) > SEND_CAP) ? SEND_CAP : int'(len);
        frame_bytes.push_back(SYNC_FIRST);
        frame_bytes.push_back(SYNC_SECOND);
        for (int i = 0; i < n + HEADER_BYTES; i++)
        begin
            if (i == 0)
                b = cls;
            else if (i == 1)
                b = id;
            else if (i == 2)
                b = len[7:0];
            else if (i == 3)
                b = len[15:8];
            else if (fill < 0)
                b = 8'($urandom_range(0, 255));
            else
                b = fill[7:0];
            sum_a = sum_a + b;
            sum_b = sum_b + sum_a;
            frame_bytes.push_back(b);
        end
        if (spoil == SPOIL_SUM_A)
            sum_a = sum_a ^ 8'($urandom_range(1, 255));
        if (spoil == SPOIL_SUM_B)
            sum_b = sum_b ^ 8'($urandom_range(1, 255));
        frame_bytes.push_back(sum_a);
        frame_bytes.push_back(sum_b);
        stop = (cut >= 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
        for (int i = 0; i < stop; i++)
            send_byte(frame_bytes[i]);
    endtask

    // sync hunting: stray bytes, broken sync pairs, then recovery
    task automatic test_sync_hunt();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_SECOND);
        send_byte(SYNC_FIRST);
        send_byte(8'h00);
        // a repeated first sync byte is not taken as a fresh start
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(8'h01);
        send_frame(8'h01, 8'h07, 16'd0, FILL_RANDOM, SPOIL_NONE, NO_CUT);
        settle_results();
    endtask

    // short frames: empty payload, extreme values, both checksum bytes wrong in turn
    task automatic test_short_frames();
        send_frame(8'hFF, 8'h00, 16'd0, FILL_RANDOM, SPOIL_NONE, NO_CUT);
        send_frame(8'h00, 8'hFF, 16'd2, 8'hFF, SPOIL_NONE, NO_CUT);
        send_frame(8'h06, 8'h01, 16'd1, 8'h00, SPOIL_SUM_A, NO_CUT);
        send_frame(8'h0A, 8'h04, 16'd0, FILL_RANDOM, SPOIL_SUM_B, NO_CUT);
        settle_results();
    endtask

    // longest frame that fits, one byte over, and the start of a huge declared length
    task automatic test_length_limit();
        // flush any frame left open by earlier traffic
        while (rx_phase != PH_HUNT)
            send_byte(8'h00);
        send_frame(8'h02, 8'h15, 16'(BODY_LIMIT - HEADER_BYTES), FILL_RANDOM,
                   SPOIL_NONE, NO_CUT);
        settle_results();
        send_frame(8'h02, 8'h13, 16'(BODY_LIMIT - HEADER_BYTES + 1), FILL_RANDOM,
                   SPOIL_NONE, NO_CUT);
        settle_results();
        send_frame(8'h0D, 8'h01, 16'hFFFF, FILL_RANDOM, SPOIL_NONE, HUGE_CUT);
        settle_results();
    endtask

    // frames back to back with no idling on either side
    task automatic test_back_to_back();
        calm = 1'b1;
        send_frame(8'h01, 8'h02, 16'd0, FILL_RANDOM, SPOIL_NONE, NO_CUT);
        send_frame(8'h01, 8'h03, 16'd5, FILL_RANDOM, SPOIL_NONE, NO_CUT);
        send_frame(8'h05, 8'h01, 16'd1, FILL_RANDOM, SPOIL_SUM_B, NO_CUT);
        send_frame(8'h01, 8'h35, 16'd3, FILL_RANDOM, SPOIL_NONE, NO_CUT);
        calm = 1'b0;
        settle_results();
    endtask

    function automatic logic [15:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'd0;
        if (r < 90)
            return 16'($urandom_range(1, 24));
        return 16'($urandom_range(25, 60));
    endfunction

    // random traffic: mostly well-formed frames, some damaged, cut short or noise
    task automatic test_random_traffic();
        int start;
        int r;
        int burst;
        logic [15:0] len;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            calm = ($urandom_range(0, 99) < 15);
            r = $urandom_range(0, 99);
            len = pick_len();
            if (r < 70)
                send_frame(8'($urandom), 8'($urandom), len, FILL_RANDOM, SPOIL_NONE, NO_CUT);
            else if (r < 80)
                send_frame(8'($urandom), 8'($urandom), len, FILL_RANDOM,
                           $urandom_range(SPOIL_SUM_A, SPOIL_SUM_B), NO_CUT);
            else if (r < 87)
                send_frame(8'($urandom), 8'($urandom), len, FILL_RANDOM, SPOIL_NONE,
                           $urandom_range(1, int'(len) + 7));
            else if (r < 96)
            begin
                burst = $urandom_range(1, 6);
                repeat (burst)
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_byte(SYNC_FIRST);
                    else
                        send_byte(8'($urandom_range(0, 255)));
                end
            end
            else
                settle_results();
        end
        calm = 1'b0;
        settle_results();
    endtask

    // result side: random stalls on ready
    initial
    begin
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (stall_left == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // result checker: each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (items_due.size() == 0)
                report_mismatch("unexpected result, kind", int'(res_ch.kind), -1);
            else
            begin
                want = items_due.pop_front();
                if (res_ch.kind !== want.kind)
                    report_mismatch("kind", int'(res_ch.kind), int'(want.kind));
                if (res_ch.body_byte !== want.body_byte)
                    report_mismatch("body_byte", int'(res_ch.body_byte), int'(want.body_byte));
                if (res_ch.byte_index !== want.byte_index)
                    report_mismatch("byte_index", int'(res_ch.byte_index),
                                    int'(want.byte_index));
                if (res_ch.frame_last !== want.frame_last)
                    report_mismatch("frame_last", int'(res_ch.frame_last),
                                    int'(want.frame_last));
            end
            case (res_ch.kind)
                KIND_BODY:  seen_body++;
                KIND_GOOD:  seen_good++;
                KIND_BAD:   seen_bad++;
                KIND_ABORT: seen_abort++;
                default:    ;
            endcase
        end
    end

    // main sequence
    initial
    begin
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_sync_hunt();
        test_short_frames();
        test_back_to_back();
        test_random_traffic();
        test_length_limit();

        settle_results();
        repeat (10) @(posedge clk);
        while (items_due.size() != 0)
        begin
            want = items_due.pop_front();
            report_mismatch("missing result, kind", -1, int'(want.kind));
        end

        $display("sent %0d bytes; saw %0d body bytes, %0d good frames, %0d bad frames",
                 bytes_sent, seen_body, seen_good, seen_bad);
        $display("and %0d aborted frames; %0d mismatches", seen_abort, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: filelist.f
sv/ubx_rx_pkg.sv
sv/ubx_rx_if.sv
sv/ubx_frame_receiver_core.sv
tb/sv/ubx_frame_receiver_core_tb.sv
